### rtl/stt_pkg.sv
// Shared constants, codes and beat/struct types for the sorted record table.
package stt_pkg;

   localparam int TABLE_DEPTH = 64;
   // Keys are taken from the low KEY_WIDTH bits of the 32-bit key field.
   localparam int KEY_WIDTH   = 32;
   localparam int PAY_W       = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W     = KEY_WIDTH + PAY_W + 1;

   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_UPDATE = 2'd2;
   localparam logic [1:0] CMD_DELETE = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_DUP  = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] key_in;
      logic [31:0] payload_in;
      logic        deleted_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] payload_out;
      logic        deleted_out;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic fin;
      logic shift;
      logic wr_new;
      logic post;
   } ctl_type;

   typedef struct packed {
      logic scan_done;
      logic go_shift;
      logic go_write;
      logic shift_done;
      logic out_free;
   } sts_type;

endpackage

### rtl/stt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### rtl/stt_ctrl.sv
// Sequencing state machine for the sorted record table.
module stt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             idle,
   input  stt_pkg::sts_type sts,
   output stt_pkg::ctl_type ctl
);
   import stt_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_FIN   = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_WRITE = 3'd4;
   localparam logic [2:0] S_POST  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_IDLE: begin
            ctl.load = req_valid;
            if (req_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            ctl.scan = 1'b1;
            if (sts.scan_done) state_in = S_FIN;
         end
         S_FIN: begin
            ctl.fin = 1'b1;
            priority if (sts.go_shift) state_in = S_SHIFT;
            else if (sts.go_write)     state_in = S_WRITE;
            else                       state_in = S_POST;
         end
         S_SHIFT: begin
            ctl.shift = 1'b1;
            if (sts.shift_done) state_in = S_WRITE;
         end
         S_WRITE: begin
            ctl.wr_new = 1'b1;
            state_in   = S_POST;
         end
         S_POST: begin
            ctl.post = sts.out_free;
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == S_IDLE);
endmodule

### rtl/stt_dp.sv
// Datapath: record memory, scan and shift pointers, entry count, result register.
module stt_dp (
   input  logic             clock,
   input  logic             reset,
   input  stt_pkg::req_type req,
   input  stt_pkg::ctl_type ctl,
   output stt_pkg::sts_type sts,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output stt_pkg::rsp_type rsp
);
   import stt_pkg::*;

   req_type            req_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   ridx_ff;
   logic               dv_ff;
   logic               posf_ff;
   logic [CNT_W-1:0]   pos_ff;
   logic [CNT_W-1:0]   j_ff;
   logic               found_ff;
   logic               dup_ff;
   logic               drop_ff;
   logic [ENTRY_W-1:0] cap_ff;
   logic [CNT_W-1:0]   r_ff;
   logic [CNT_W-1:0]   w_ff;
   logic               sdv_ff;
   rsp_type            res_ff;
   rsp_type            rsp_ff;
   logic               rsp_vld_ff;

   logic               we;
   logic [IDX_W-1:0]   waddr;
   logic [ENTRY_W-1:0] wdata;
   logic [IDX_W-1:0]   raddr;
   logic [ENTRY_W-1:0] rdata;

   logic [KEY_WIDTH-1:0] ek, qk;
   logic                 ed;
   logic [CNT_W-1:0]     c;
   logic                 last, eq, gt, is_add, full, add_ok;
   logic [CNT_W-1:0]     jj;
   logic                 scan_done;
   rsp_type              res_in;

   stt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign ek     = rdata[ENTRY_W-1 -: KEY_WIDTH];
   assign ed     = rdata[0];
   assign qk     = req_ff.key_in[KEY_WIDTH-1:0];
   assign c      = ridx_ff - 1'b1;
   assign eq     = dv_ff && (ek == qk);
   assign gt     = dv_ff && (ek > qk);
   assign last   = dv_ff && (ridx_ff == count_ff);
   assign is_add = (req_ff.command == CMD_ADD);
   assign full   = (count_ff == CNT_W'(TABLE_DEPTH));
   assign add_ok = is_add && !dup_ff && (drop_ff || !full);
   assign jj     = drop_ff ? j_ff : count_ff;

   // Scan termination for the entry whose data sits on the read port.
   always_comb begin
      scan_done = 1'b0;
      if (!dv_ff) begin
         scan_done = (count_ff == '0);
      end else if (!is_add) begin
         scan_done = eq || gt || last;
      end else if (!posf_ff) begin
         scan_done = eq || (gt && ed) || last;
      end else begin
         scan_done = ed || last;
      end
   end

   assign sts.scan_done  = scan_done;
   assign sts.go_shift   = add_ok && (jj != pos_ff);
   assign sts.go_write   = add_ok && (jj == pos_ff);
   assign sts.shift_done = sdv_ff && (w_ff == pos_ff + 1'b1);
   assign sts.out_free   = !rsp_vld_ff || rsp_ready;

   always_comb begin
      res_in             = '0;
      if (is_add) begin
         priority if (dup_ff) res_in.status = ST_DUP;
         else if (!add_ok)    res_in.status = ST_FULL;
         else                 res_in.status = ST_OK;
      end else begin
         res_in.status = found_ff ? ST_OK : ST_MISS;
         if (found_ff && req_ff.command == CMD_FIND) begin
            res_in.payload_out = cap_ff[PAY_W:1];
            res_in.deleted_out = cap_ff[0];
         end
      end
   end

   // One write port: update/delete in place, shift step, or new record.
   always_comb begin
      we    = 1'b0;
      waddr = pos_ff[IDX_W-1:0];
      wdata = {qk, req_ff.payload_in, req_ff.deleted_in};
      raddr = ridx_ff[IDX_W-1:0];
      if (ctl.shift) raddr = r_ff[IDX_W-1:0];
      priority if (ctl.fin && found_ff && !is_add) begin
         we = (req_ff.command == CMD_UPDATE) || (req_ff.command == CMD_DELETE);
         if (req_ff.command == CMD_DELETE) wdata = {cap_ff[ENTRY_W-1:1], 1'b1};
      end else if (ctl.shift) begin
         we    = sdv_ff;
         waddr = w_ff[IDX_W-1:0];
         wdata = rdata;
      end else if (ctl.wr_new) begin
         we = 1'b1;
      end else begin
         we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff   <= req;
         ridx_ff  <= '0;
         dv_ff    <= 1'b0;
         posf_ff  <= 1'b0;
         found_ff <= 1'b0;
         dup_ff   <= 1'b0;
         drop_ff  <= 1'b0;
      end
      if (ctl.scan) begin
         ridx_ff <= ridx_ff + 1'b1;
         dv_ff   <= 1'b1;
         if (!dv_ff) begin
            pos_ff <= count_ff;
         end else if (!is_add) begin
            if (eq) begin
               found_ff <= 1'b1;
               pos_ff   <= c;
               cap_ff   <= rdata;
            end
         end else if (!posf_ff) begin
            if (eq) begin
               dup_ff <= 1'b1;
            end else if (gt) begin
               pos_ff  <= c;
               posf_ff <= 1'b1;
               if (ed) begin
                  drop_ff <= 1'b1;
                  j_ff    <= c;
               end
            end else if (last) begin
               pos_ff <= count_ff;
            end
         end else if (ed) begin
            drop_ff <= 1'b1;
            j_ff    <= c;
         end
      end
      if (ctl.fin) begin
         res_ff <= res_in;
         if (sts.go_shift) begin
            r_ff   <= jj - 1'b1;
            sdv_ff <= 1'b0;
         end
      end
      if (ctl.shift) begin
         w_ff   <= r_ff + 1'b1;
         r_ff   <= r_ff - 1'b1;
         sdv_ff <= 1'b1;
      end
      if (ctl.post) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (ctl.fin && add_ok && !drop_ff) count_ff <= count_ff + 1'b1;
         if (ctl.post) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_vld_ff;
endmodule

### rtl/sorted_table_with_tombstones.sv
// Top level of the sorted record table with deleted marks.
//
//   channel   direction  handshake              beat
//   req_      in         req_valid / req_ready  stt_pkg::req_type
//   rsp_      out        rsp_valid / rsp_ready  stt_pkg::rsp_type
//
// One command at a time. The scan reads one record per cycle from the record
// RAM (registered read); find, update and delete end after the scan. Add adds
// a shift pass of one record per cycle over the displaced span. Both passes
// run on the single RAM port pair.
// Reset (synchronous) empties the table; no clearing pass is needed.
// A result waiting on rsp_ready holds only the final post step; the next
// command is taken as soon as its result is registered.
module sorted_table_with_tombstones (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stt_pkg::rsp_type rsp_data
);
   import stt_pkg::*;

   ctl_type ctl;
   sts_type sts;

   // Sequencer: walks scan, decide, shift, write and post steps.
   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .idle      (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   // Datapath: holds the records, the count and the result register.
   stt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

`ifndef SYNTH
   // Hold off new beats while a command is being worked on.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted a beat while busy");

   // Never overwrite a result that has not been taken.
   a_post_free: assert property (@(posedge clock) disable iff (reset)
      ctl.post |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten");

   // A posted result shows up on the port next cycle.
   a_post_vld: assert property (@(posedge clock) disable iff (reset)
      ctl.post |=> rsp_valid)
      else $error("posted result missing");

   // No table work while idle.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(ctl.scan || ctl.shift || ctl.wr_new || ctl.fin))
      else $error("datapath active while idle");
`endif
endmodule

### sim/tb_sorted_table_with_tombstones.sv
// Testbench for the sorted record table: directed and random commands checked against a predictor.
module tb_sorted_table_with_tombstones;
   import stt_pkg::*;

   // Predictor of the record table and queue of expected responses.
   class table_scoreboard;
      logic [31:0] keys[$];
      logic [31:0] pays[$];
      logic        marks[$];
      rsp_type     pending[$];
      int          errors;

      function void note_request(req_type r);
         rsp_type e;
         int      pos;
         int      hit;
         int      drop;
         e = '0;
         pos = keys.size();
         hit = -1;
         // find first key that is equal or larger
         for (int i = 0; i < keys.size(); i++) begin
            if (keys[i] == r.key_in) begin
               hit = i;
               pos = i;
               break;
            end
            if (keys[i] > r.key_in) begin
               pos = i;
               break;
            end
         end
         if (r.command == CMD_ADD) begin
            if (hit >= 0) begin
               e.status = ST_DUP;
            end else begin
               drop = -1;
               for (int j = pos; j < keys.size(); j++) begin
                  if (marks[j]) begin
                     drop = j;
                     break;
                  end
               end
               if (drop < 0 && keys.size() >= TABLE_DEPTH) begin
                  e.status = ST_FULL;
               end else begin
                  // drop the first displaced tombstone, then insert
                  if (drop >= 0) begin
                     keys.delete(drop);
                     pays.delete(drop);
                     marks.delete(drop);
                  end
                  keys.insert(pos, r.key_in);
                  pays.insert(pos, r.payload_in);
                  marks.insert(pos, r.deleted_in);
                  e.status = ST_OK;
               end
            end
         end else if (hit < 0) begin
            e.status = ST_MISS;
         end else if (r.command == CMD_FIND) begin
            e.status = ST_OK;
            e.payload_out = pays[hit];
            e.deleted_out = marks[hit];
         end else if (r.command == CMD_UPDATE) begin
            pays[hit] = r.payload_in;
            marks[hit] = r.deleted_in;
         end else begin
            marks[hit] = 1'b1;
         end
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected response status=%0d", a.status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, a.status);
            errors++;
         end
         if (a.payload_out !== e.payload_out) begin
            $error("payload_out: expected %h actual %h", e.payload_out, a.payload_out);
            errors++;
         end
         if (a.deleted_out !== e.deleted_out) begin
            $error("deleted_out: expected %0d actual %0d", e.deleted_out, a.deleted_out);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   table_scoreboard board;
   int  send_idle_pct;
   int  recv_idle_pct;
   bit  hold_off;
   int  hold_cycles;
   longint cycle_count;
   logic [31:0] key_pool[16];

   sorted_table_with_tombstones i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard limit: fails the run if the worst-case command time plus stalls, taken many times over, is exceeded.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > 1500000) begin
            $display("sorted_table_with_tombstones regression: fail");
            $finish;
         end
      end
   end

   // Receiver: random backpressure, or a long hold-off when requested.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready && !reset)
            board.check_response(rsp_data);
         if (hold_off && hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            hold_off = 1'b0;
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Drive one beat and wait until accepted; random gap before it.
   // Valid stays up after the beat; the next beat replaces it, an idle gap or drain drops it.
   task automatic send_beat(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      board.note_request(r);
   endtask

   task automatic send_cmd(logic [1:0] c, logic [31:0] k, logic [31:0] p, logic d);
      req_type r;
      r.command = c;
      r.key_in = k;
      r.payload_in = p;
      r.deleted_in = d;
      send_beat(r);
   endtask

   // Drop valid, then pause until every expected response is back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      int s;
      s = $urandom_range(9);
      // mostly reuse a small pool so hits, duplicates and tombstones occur
      if (s < 8) return key_pool[$urandom_range(15)];
      return $urandom();
   endfunction

   task automatic random_phase(int count);
      int c;
      for (int n = 0; n < count; n++) begin
         c = $urandom_range(9);
         // favor adds over the other commands
         if (c < 4)
            send_cmd(CMD_ADD, pick_key(), $urandom(), ($urandom_range(3) == 0));
         else
            send_cmd(2'($urandom_range(3)), pick_key(), $urandom(), 1'($urandom_range(1)));
      end
   endtask

   initial begin
      board = new();
      req_valid = 1'b0;
      req_data  = '0;
      reset = 1'b1;
      hold_off = 1'b0;
      hold_cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 16; i++) key_pool[i] = $urandom();
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: misses on empty table, extremes, duplicate, tombstone paths.
      send_cmd(CMD_FIND, 32'h0, 32'h0, 1'b0);
      send_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      send_cmd(CMD_ADD, 32'h0, 32'h0, 1'b0);
      send_cmd(CMD_ADD, 32'h8000_0000, 32'hA5A5_5A5A, 1'b0);
      send_cmd(CMD_ADD, 32'h8000_0000, 32'h1, 1'b0);
      send_cmd(CMD_FIND, 32'hFFFF_FFFF, 32'h0, 1'b0);
      send_cmd(CMD_FIND, 32'h8000_0000, 32'h0, 1'b0);
      send_cmd(CMD_FIND, 32'h4000_0000, 32'h0, 1'b0);
      send_cmd(CMD_UPDATE, 32'h0, 32'h5A5A_A5A5, 1'b1);
      send_cmd(CMD_UPDATE, 32'h1234, 32'h1, 1'b0);
      send_cmd(CMD_DELETE, 32'h8000_0000, 32'h0, 1'b0);
      send_cmd(CMD_DELETE, 32'h8000_0000, 32'h0, 1'b0);
      send_cmd(CMD_DELETE, 32'h7, 32'h0, 1'b0);
      send_cmd(CMD_ADD, 32'h10, 32'h77, 1'b0);
      send_cmd(CMD_FIND, 32'h0, 32'h0, 1'b0);
      send_cmd(CMD_UPDATE, 32'h0, 32'h3, 1'b0);
      send_cmd(CMD_FIND, 32'h10, 32'h0, 1'b0);
      drain();

      // Fill to capacity with live records, then hit table full.
      for (int i = 0; i < 70; i++)
         send_cmd(CMD_ADD, 32'(i * 3 + 100), $urandom(), 1'b0);
      send_cmd(CMD_DELETE, 32'd160, 32'h0, 1'b0);
      send_cmd(CMD_ADD, 32'd101, 32'hDEAD_BEEF, 1'b0);
      send_cmd(CMD_ADD, 32'd400, 32'h1, 1'b0);
      send_cmd(CMD_FIND, 32'd101, 32'h0, 1'b0);

      // Long receiver hold-off while the sender keeps offering beats.
      hold_cycles = 400;
      hold_off = 1'b1;
      random_phase(20);
      drain();

      // Random phases under both idle mixes, then with no idling.
      send_idle_pct = 38;
      recv_idle_pct = 65;
      random_phase(250);
      send_idle_pct = 65;
      recv_idle_pct = 38;
      random_phase(250);
      drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(250);

      drain();
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("sorted_table_with_tombstones regression: pass");
      else
         $display("sorted_table_with_tombstones regression: fail");
      $finish;
   end

endmodule
